// ----- hw/rtl/ppaa_pkg.sv -----
// Shared types, widths and constants for the polygon annulus area block.
`default_nettype none
package ppaa_pkg;
    localparam int COORD_BITS_DEF = 21;
    localparam int FRAC_BITS_DEF  = 8;
    localparam int MIN_BITS  = 52;
    localparam int MAX_BITS  = 44;
    localparam int AREA_BITS = 54;
    localparam logic [63:0] PI_Q60 = 64'h3243F6A8885A308D;

    localparam logic ADDR_CX = 1'b0;
    localparam logic ADDR_CY = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_VERT,
        ST_EDGE_SETUP,
        ST_EDGE_SQ,
        ST_EDGE_DIV,
        ST_EDGE_TAKE,
        ST_AREA_MUL,
        ST_AREA_LOAD,
        ST_OUT
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_vertex;
        logic load_first;
        logic take_vertex;
        logic edge_prev;
        logic edge_close;
        logic edge_setup;
        logic edge_square;
        logic div_step;
        logic edge_take;
        logic area_start;
        logic area_step;
        logic out_load;
        logic clear_run;
    } cmd_t;

    typedef struct packed {
        logic edge_ok;
        logic div_done;
        logic area_done;
    } stat_t;
endpackage
`default_nettype wire

// ----- hw/rtl/ppaa_ctrl.sv -----
// Sequencer for one vertex: vertex distance, edge projections, area.
`default_nettype none
module ppaa_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_stall,
    input  wire logic          in_last,
    input  wire logic          out_stall,
    output logic               out_valid,
    input  wire ppaa_pkg::stat_t stat,
    output ppaa_pkg::cmd_t     cmd
);
    import ppaa_pkg::*;

    state_t state_reg, state_next;
    logic   have_first_reg, have_first_next;
    logic   last_reg, last_next;
    logic   close_reg, close_next;
    logic   out_valid_reg, out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            have_first_reg <= 1'b0;
            last_reg       <= 1'b0;
            close_reg      <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            have_first_reg <= have_first_next;
            last_reg       <= last_next;
            close_reg      <= close_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign in_stall  = (state_reg != ST_IDLE);

    always_comb
    begin
        state_next      = state_reg;
        have_first_next = have_first_reg;
        last_next       = last_reg;
        close_next      = close_reg;
        out_valid_next  = out_valid_reg;
        cmd             = '0;
        if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_vertex = 1'b1;
                    last_next       = in_last;
                    close_next      = 1'b0;
                    state_next      = ST_VERT;
                end
            end
            ST_VERT:
            begin
                // Edge from the previous vertex runs before this vertex is stored.
                if (have_first_reg)
                begin
                    cmd.edge_prev = 1'b1;
                    state_next    = ST_EDGE_SETUP;
                end
                else
                begin
                    // A lone vertex closes on itself: zero-length edge, skip it.
                    cmd.take_vertex = 1'b1;
                    cmd.load_first  = 1'b1;
                    have_first_next = 1'b1;
                    state_next      = last_reg ? ST_AREA_LOAD : ST_IDLE;
                end
            end
            ST_EDGE_SETUP:
            begin
                cmd.edge_setup = 1'b1;
                state_next     = ST_EDGE_SQ;
            end
            ST_EDGE_SQ:
            begin
                cmd.edge_square = 1'b1;
                state_next      = ST_EDGE_DIV;
            end
            ST_EDGE_DIV:
            begin
                if (!stat.edge_ok)
                    state_next = ST_EDGE_TAKE;
                else
                begin
                    cmd.div_step = 1'b1;
                    if (stat.div_done)
                        state_next = ST_EDGE_TAKE;
                end
            end
            ST_EDGE_TAKE:
            begin
                cmd.edge_take = stat.edge_ok;
                if (close_reg)
                    state_next = ST_AREA_LOAD;
                else
                begin
                    cmd.take_vertex = 1'b1;
                    if (last_reg)
                    begin
                        cmd.edge_close = 1'b1;
                        close_next     = 1'b1;
                        state_next     = ST_EDGE_SETUP;
                    end
                    else
                        state_next = ST_IDLE;
                end
            end
            ST_AREA_LOAD:
            begin
                // Running minimum is final here.
                cmd.area_start = 1'b1;
                state_next     = ST_AREA_MUL;
            end
            ST_AREA_MUL:
            begin
                cmd.area_step = 1'b1;
                if (stat.area_done)
                    state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.out_load    = 1'b1;
                    cmd.clear_run   = 1'b1;
                    out_valid_next  = 1'b1;
                    have_first_next = 1'b0;
                    state_next      = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end
endmodule
`default_nettype wire

// ----- hw/rtl/ppaa_dp.sv -----
// Datapath: distances, serial divider, serial area multiplier, result registers.
`default_nettype none
module ppaa_dp #(
    parameter int COORD_BITS = ppaa_pkg::COORD_BITS_DEF,
    parameter int FRAC_BITS  = ppaa_pkg::FRAC_BITS_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire ppaa_pkg::cmd_t                cmd,
    output ppaa_pkg::stat_t                    stat,
    input  wire logic signed [COORD_BITS-1:0]  cx,
    input  wire logic signed [COORD_BITS-1:0]  cy,
    input  wire logic signed [COORD_BITS-1:0]  vx,
    input  wire logic signed [COORD_BITS-1:0]  vy,
    output logic [ppaa_pkg::AREA_BITS-1:0]     area_q8,
    output logic [ppaa_pkg::MIN_BITS-1:0]      min_dist_sq_q8,
    output logic [ppaa_pkg::MAX_BITS-1:0]      max_dist_sq
);
    import ppaa_pkg::*;

    localparam int DW = COORD_BITS + 1;        // coordinate differences
    localparam int SW = 2 * DW + 1;            // squared lengths and dots
    localparam int QW = SW + FRAC_BITS;        // quotient below len << FRAC
    localparam int CW = $clog2(SW + FRAC_BITS + 2);
    localparam int MW = 64;                    // area operand width
    localparam int MCW = $clog2(MW + 1);

    logic signed [COORD_BITS-1:0] cur_x_reg, cur_y_reg, prev_x_reg, prev_y_reg;
    logic signed [COORD_BITS-1:0] first_x_reg, first_y_reg;
    logic signed [COORD_BITS-1:0] ax_reg, ay_reg, bx_reg, by_reg;
    logic [MIN_BITS-1:0] min_reg, min_next, min_v;
    logic [MAX_BITS-1:0] max_reg;
    logic signed [DW-1:0] abx_reg, aby_reg, arx_reg, ary_reg;
    logic signed [SW-1:0] len_reg, dot_reg, ar2_reg;
    logic [SW-1:0]        m_reg;
    logic [SW:0]          rem_reg;
    logic [QW-1:0]        q_reg;
    logic [CW-1:0]        cnt_reg;
    logic                 ok_reg;
    logic [MW-1:0]        md_reg;
    logic [MW+AREA_BITS+4-1:0] acc_reg;
    logic [63:0]          mp_reg;
    logic [MCW-1:0]       mcnt_reg;

    // Vertex distance.
    logic signed [DW-1:0] vdx, vdy;
    logic [SW-1:0] vd;
    logic [MIN_BITS-1:0] vd_q;
    assign vdx = DW'(cur_x_reg) - DW'(cx);
    assign vdy = DW'(cur_y_reg) - DW'(cy);
    assign vd  = SW'(vdx * vdx) + SW'(vdy * vdy);
    assign vd_q = MIN_BITS'(vd) << FRAC_BITS;

    logic [SW+FRAC_BITS-1:0] ar2_q, cut;
    assign ar2_q  = (SW+FRAC_BITS)'(ar2_reg) << FRAC_BITS;
    assign cut    = (SW+FRAC_BITS)'(q_reg) + ((rem_reg != '0) ? 1'b1 : 1'b0);

    // Interleaved multiply-divide: (dot << FRAC) * dot / len, one multiplier
    // bit per step, MSB first; the partial sum stays below 3 * len.
    logic [SW:0] len1, len2, part, rem_nx;
    logic [1:0]  digit;
    assign len1 = {1'b0, len_reg};
    assign len2 = {len_reg, 1'b0};
    assign part = {rem_reg[SW-1:0], 1'b0} + (m_reg[SW-1] ? {1'b0, dot_reg} : '0);

    always_comb
    begin
        priority if (part >= len2)
        begin
            digit  = 2'd2;
            rem_nx = part - len2;
        end
        else if (part >= len1)
        begin
            digit  = 2'd1;
            rem_nx = part - len1;
        end
        else
        begin
            digit  = 2'd0;
            rem_nx = part;
        end
    end

    logic [MIN_BITS-1:0] foot;
    assign foot = (cut <= ar2_q) ? MIN_BITS'(ar2_q - cut) : '0;

    assign min_v    = (cmd.take_vertex && vd_q < min_reg) ? vd_q : min_reg;
    assign min_next = (cmd.edge_take && foot < min_v) ? foot : min_v;

    logic [MW-1:0] diff;
    logic [MW-1:0] maxq;
    assign maxq = MW'(max_reg) << FRAC_BITS;
    assign diff = (maxq >= MW'(min_reg)) ? maxq - MW'(min_reg) : '0;

    always_ff @(posedge clk)
    begin
        if (cmd.load_vertex)
        begin
            cur_x_reg <= vx;
            cur_y_reg <= vy;
        end
        if (cmd.take_vertex)
        begin
            prev_x_reg <= cur_x_reg;
            prev_y_reg <= cur_y_reg;
        end
        if (cmd.edge_prev)
        begin
            ax_reg <= prev_x_reg; ay_reg <= prev_y_reg;
            bx_reg <= cur_x_reg;  by_reg <= cur_y_reg;
        end
        if (cmd.edge_close)
        begin
            ax_reg <= cur_x_reg;  ay_reg <= cur_y_reg;
            bx_reg <= first_x_reg; by_reg <= first_y_reg;
        end
        if (cmd.edge_setup)
        begin
            abx_reg <= DW'(bx_reg) - DW'(ax_reg);
            aby_reg <= DW'(by_reg) - DW'(ay_reg);
            arx_reg <= DW'(cx) - DW'(ax_reg);
            ary_reg <= DW'(cy) - DW'(ay_reg);
        end
        if (cmd.edge_square)
        begin
            len_reg <= SW'(abx_reg * abx_reg) + SW'(aby_reg * aby_reg);
            dot_reg <= SW'(abx_reg * arx_reg) + SW'(aby_reg * ary_reg);
            ar2_reg <= SW'(arx_reg * arx_reg) + SW'(ary_reg * ary_reg);
        end
        if (cmd.div_step)
        begin
            if (cnt_reg == '0)
            begin
                // First step loads dot as the multiplier bits.
                m_reg   <= dot_reg;
                rem_reg <= '0;
                q_reg   <= '0;
            end
            else
            begin
                m_reg   <= m_reg << 1;
                rem_reg <= rem_nx;
                q_reg   <= {q_reg[QW-2:0], 1'b0} + QW'(digit);
            end
        end
        if (cmd.area_start)
        begin
            md_reg  <= diff;
            mp_reg  <= PI_Q60;
            acc_reg <= '0;
        end
        else if (cmd.area_step)
        begin
            if (md_reg[0])
                acc_reg <= acc_reg + ((MW+AREA_BITS+4)'(mp_reg) << mcnt_reg);
            md_reg <= md_reg >> 1;
        end
        if (cmd.out_load)
        begin
            area_q8        <= AREA_BITS'(acc_reg >> 60);
            min_dist_sq_q8 <= min_reg;
            max_dist_sq    <= max_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_reg     <= '1;
            max_reg     <= '0;
            first_x_reg <= '0;
            first_y_reg <= '0;
            cnt_reg     <= '0;
            ok_reg      <= 1'b0;
            mcnt_reg    <= '0;
        end
        else
        begin
            if (cmd.edge_square)
            begin
                cnt_reg <= '0;
            end
            if (cmd.div_step)
                cnt_reg <= cnt_reg + 1'b1;
            if (cmd.edge_square)
                ok_reg <= 1'b1;
            else if (cmd.edge_setup)
                ok_reg <= 1'b0;
            if (cmd.area_start)
                mcnt_reg <= '0;
            else if (cmd.area_step)
                mcnt_reg <= mcnt_reg + 1'b1;
            if (cmd.take_vertex && MAX_BITS'(vd) > max_reg)
                max_reg <= MAX_BITS'(vd);
            if (cmd.load_first)
            begin
                first_x_reg <= cur_x_reg;
                first_y_reg <= cur_y_reg;
            end
            if (cmd.clear_run)
            begin
                min_reg <= '1;
                max_reg <= '0;
            end
            else
                min_reg <= min_next;
        end
    end

    // Projection applies only for 0 < dot < len.
    logic edge_ok;
    assign edge_ok = ok_reg && (len_reg != '0) && (dot_reg > 0) && (dot_reg < len_reg);
    assign stat.edge_ok   = edge_ok;
    assign stat.div_done  = (cnt_reg == CW'(SW + FRAC_BITS));
    assign stat.area_done = (mcnt_reg == MCW'(MW - 1));
endmodule
`default_nettype wire

// ----- hw/rtl/polygon_point_annulus_area.sv -----
// Top level of the polygon annulus area block.
// Vertices arrive on a valid/stall channel: vertex_x, vertex_y, last_vertex.
// The centre point is written over an APB-style port: centre_x at 0x0,
// centre_y at 0x4; the user writes it while no vertex is in work, unchecked.
// One vertex is taken at a time; in_stall is high while it is processed.
// The first vertex of a polygon runs no edge. Any other vertex also runs its
// edge (setup, squares) and, when the edge needs a projection, the
// interleaved multiply-divide that takes one bit of dot per cycle. The last
// vertex adds the closing edge (unless it is also the first) and a shift-add
// multiply of the 64-bit area operand before out_valid rises.
// The result (area_q8, min_dist_sq_q8, max_dist_sq) is held in an output
// register with out_valid until out_stall is low; the next polygon's vertices
// are taken while it waits, up to the next last vertex.
// Reset clears the running minimum to all ones, maximum to zero, the centre
// to zero and empties the output register.
`default_nettype none
module polygon_point_annulus_area #(
    parameter int COORD_BITS = ppaa_pkg::COORD_BITS_DEF,
    parameter int FRAC_BITS  = ppaa_pkg::FRAC_BITS_DEF
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [2:0]                   paddr,
    input  wire logic [31:0]                  pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready,
    input  wire logic                         in_valid,
    output logic                              in_stall,
    input  wire logic signed [COORD_BITS-1:0] vertex_x,
    input  wire logic signed [COORD_BITS-1:0] vertex_y,
    input  wire logic                         last_vertex,
    output logic                              out_valid,
    input  wire logic                         out_stall,
    output logic [ppaa_pkg::AREA_BITS-1:0]    area_q8,
    output logic [ppaa_pkg::MIN_BITS-1:0]     min_dist_sq_q8,
    output logic [ppaa_pkg::MAX_BITS-1:0]     max_dist_sq
);
    import ppaa_pkg::*;

    logic signed [COORD_BITS-1:0] cx_reg, cy_reg;
    cmd_t  cmd;
    stat_t stat;

    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cx_reg <= '0;
            cy_reg <= '0;
        end
        else if (psel && penable && pwrite && paddr[1:0] == 2'b00)
        begin
            if (paddr[2] == ADDR_CX)
                cx_reg <= pwdata[COORD_BITS-1:0];
            else
                cy_reg <= pwdata[COORD_BITS-1:0];
        end
    end

    always_comb
    begin
        prdata = '0;
        if (paddr[1:0] == 2'b00)
            prdata = (paddr[2] == ADDR_CX) ? 32'(cx_reg) : 32'(cy_reg);
    end

    ppaa_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_last   (last_vertex),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .stat      (stat),
        .cmd       (cmd)
    );

    ppaa_dp #(
        .COORD_BITS (COORD_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .stat           (stat),
        .cx             (cx_reg),
        .cy             (cy_reg),
        .vx             (vertex_x),
        .vy             (vertex_y),
        .area_q8        (area_q8),
        .min_dist_sq_q8 (min_dist_sq_q8),
        .max_dist_sq    (max_dist_sq)
    );
endmodule
`default_nettype wire

// ----- hw/rtl/ppaa_checker.sv -----
// Port-level checker for the polygon annulus area block, with its bind.
`default_nettype none
module ppaa_checker (
    input wire logic clk,
    input wire logic rst_n,
    input wire logic in_valid,
    input wire logic in_stall,
    input wire logic out_valid,
    input wire logic out_stall,
    input wire logic [51:0] min_dist_sq_q8,
    input wire logic [43:0] max_dist_sq
);
    // A held result does not drop while stalled.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result dropped under stall");
    // A vertex transfer stalls the input on the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input not stalled after transfer");
    // A new result never appears in the cycle after an input transfer.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && !out_valid |=> !out_valid)
        else $error("result too early");
    // Held distance results keep their values.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(min_dist_sq_q8) && $stable(max_dist_sq))
        else $error("result changed under stall");
endmodule

bind polygon_point_annulus_area ppaa_checker u_ppaa_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .min_dist_sq_q8 (min_dist_sq_q8),
    .max_dist_sq    (max_dist_sq)
);
`default_nettype wire

// ----- tb/sv/tb_polygon_point_annulus_area.sv -----
// Polygon annulus area testbench: directed and random polygons checked against a predictor.
`default_nettype none
module tb_polygon_point_annulus_area;
    timeunit 1ns;
    timeprecision 1ps;
    import ppaa_pkg::*;

    localparam int CB = 21;
    localparam int FB = 8;
    localparam logic [2:0] REG_CX = 3'd0;
    localparam logic [2:0] REG_CY = 3'd4;
    localparam longint CYCLE_LIMIT = 3000000;

    typedef struct packed {
        logic signed [CB-1:0] vx;
        logic signed [CB-1:0] vy;
        logic                 last;
    } vertex_t;

    typedef struct packed {
        logic [AREA_BITS-1:0] area;
        logic [MIN_BITS-1:0]  dmin;
        logic [MAX_BITS-1:0]  dmax;
    } annulus_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [2:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;
    logic in_valid = 1'b0;
    logic in_stall;
    logic signed [CB-1:0] vertex_x = '0, vertex_y = '0;
    logic last_vertex = 1'b0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic [AREA_BITS-1:0] area_q8;
    logic [MIN_BITS-1:0] min_dist_sq_q8;
    logic [MAX_BITS-1:0] max_dist_sq;

    polygon_point_annulus_area dut (.*);

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    vertex_t   pending_q[$];
    annulus_t  annulus_q[$];
    int        errors = 0;
    longint    cycles = 0;
    bit        quiet = 0;      // no idling when set
    int        holdoff = 0;

    // predictor state
    logic signed [CB-1:0] ctr_x = '0, ctr_y = '0;
    longint fx, fy, px, py;
    bit     open_poly = 0;
    logic [63:0] run_min = (64'd1 << MIN_BITS) - 1;
    logic [63:0] run_max = 0;

    function automatic void fold_edge(longint ax, longint ay, longint bx, longint by);
        logic [63:0] abx, aby, arx, ary, len, dot, ar2, cut, q;
        logic [127:0] num;
        logic [127:0] rem;
        abx = bx - ax; aby = by - ay;
        arx = longint'(ctr_x) - ax; ary = longint'(ctr_y) - ay;
        len = abx * abx + aby * aby;
        dot = abx * arx + aby * ary;
        if (len == 0 || dot == 0 || dot[63] || dot >= len)
            return;
        num = ({64'd0, dot} * {64'd0, dot}) << FB;
        q = num / len;
        rem = num % len;
        ar2 = (arx * arx + ary * ary) << FB;
        cut = q + (rem != 0);
        if ((cut <= ar2 ? ar2 - cut : 64'd0) < run_min)
            run_min = cut <= ar2 ? ar2 - cut : 64'd0;
    endfunction

    task automatic predict_vertex(vertex_t v);
        longint x, y;
        logic [63:0] d, diff, dx, dy;
        logic [127:0] prod;
        annulus_t r;
        x = v.vx; y = v.vy;
        if (!open_poly)
        begin
            fx = x; fy = y; open_poly = 1;
        end
        else
            fold_edge(px, py, x, y);
        dx = x - longint'(ctr_x); dy = y - longint'(ctr_y);
        d = dx * dx + dy * dy;
        if ((d << FB) < run_min) run_min = d << FB;
        if (d > run_max) run_max = d;
        px = x; py = y;
        if (!v.last) return;
        fold_edge(x, y, fx, fy);
        diff = run_max << FB;
        diff = diff >= run_min ? diff - run_min : 64'd0;
        prod = {64'd0, diff} * {64'd0, PI_Q60};
        r.area = prod[60 +: AREA_BITS];
        r.dmin = run_min[MIN_BITS-1:0];
        r.dmax = run_max[MAX_BITS-1:0];
        annulus_q.push_back(r);
        open_poly = 0;
        run_min = (64'd1 << MIN_BITS) - 1;
        run_max = 0;
    endtask

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // driver: advance on a transfer, idle at random between items
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (!in_valid || !in_stall)
            begin
                if (pending_q.size() > 0 && (quiet || $urandom_range(99) >= 38))
                begin
                    vertex_t v;
                    v = pending_q.pop_front();
                    predict_vertex(v);
                    vertex_x <= v.vx;
                    vertex_y <= v.vy;
                    last_vertex <= v.last;
                    in_valid <= 1'b1;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // receiver stall and result check
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (annulus_q.size() == 0)
                begin
                    $display("%0t unexpected result area %0d", $time, area_q8);
                    errors++;
                end
                else
                begin
                    annulus_t e;
                    e = annulus_q.pop_front();
                    if (e.area !== area_q8)
                    begin
                        $display("%0t area_q8 exp %0d got %0d", $time, e.area, area_q8);
                        errors++;
                    end
                    if (e.dmin !== min_dist_sq_q8)
                    begin
                        $display("%0t min_dist_sq_q8 exp %0d got %0d", $time, e.dmin,
                                 min_dist_sq_q8);
                        errors++;
                    end
                    if (e.dmax !== max_dist_sq)
                    begin
                        $display("%0t max_dist_sq exp %0d got %0d", $time, e.dmax,
                                 max_dist_sq);
                        errors++;
                    end
                end
            end
            if (holdoff > 0)
            begin
                holdoff <= holdoff - 1;
                out_stall <= 1'b1;
            end
            else
                out_stall <= !quiet && ($urandom_range(99) < 38);
        end
    end

    task automatic reg_write(logic [2:0] addr, logic [31:0] data);
        @(posedge clk);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= addr; pwdata <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        if (addr == REG_CX) ctr_x = data[CB-1:0];
        else ctr_y = data[CB-1:0];
    endtask

    task automatic drain();
        wait (pending_q.size() == 0);
        @(posedge clk);
        while (in_valid || annulus_q.size() != 0) @(posedge clk);
        // trailing vertices of an open polygon may still be in work
        repeat (400) @(posedge clk);
    endtask

    function automatic logic signed [CB-1:0] rnd_coord(int mode);
        case (mode)
            0: return CB'(-1000000);
            1: return CB'(1000000);
            2: return CB'($urandom_range(40)) - CB'(20);
            3: return CB'($urandom_range(2000)) - CB'(1000);
            default: return CB'($urandom_range(2000000)) - CB'(1000000);
        endcase
    endfunction

    task automatic add_vertex(logic signed [CB-1:0] x, logic signed [CB-1:0] y, logic l);
        vertex_t v;
        v.vx = x; v.vy = y; v.last = l;
        pending_q.push_back(v);
    endtask

    task automatic random_polygons(int count, int mode);
        int n;
        logic signed [CB-1:0] x, y;
        for (int p = 0; p < count; p++)
        begin
            n = ($urandom_range(9) == 0) ? 1 : $urandom_range(8, 2);
            for (int i = 0; i < n; i++)
            begin
                x = rnd_coord($urandom_range(9) == 0 ? $urandom_range(1) : mode);
                y = rnd_coord($urandom_range(9) == 0 ? $urandom_range(1) : mode);
                // repeat a vertex now and then for a zero-length edge
                if (i > 0 && $urandom_range(11) == 0)
                begin
                    x = pending_q[$].vx; y = pending_q[$].vy;
                end
                add_vertex(x, y, i == n - 1);
            end
        end
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        // directed: default centre
        add_vertex(CB'(5), CB'(7), 1'b1);
        add_vertex(CB'(-10), CB'(-10), 1'b0);
        add_vertex(CB'(10), CB'(-10), 1'b0);
        add_vertex(CB'(10), CB'(10), 1'b0);
        add_vertex(CB'(-10), CB'(10), 1'b1);
        add_vertex(CB'(3), CB'(3), 1'b0);
        add_vertex(CB'(3), CB'(3), 1'b1);
        add_vertex(CB'(-1000000), CB'(-1000000), 1'b0);
        add_vertex(CB'(1000000), CB'(1000000), 1'b1);
        add_vertex(CB'(-1000000), CB'(1000000), 1'b0);
        add_vertex(CB'(1000000), CB'(-1000000), 1'b1);
        drain();
        reg_write(REG_CX, 32'(-1000000));
        reg_write(REG_CY, 32'd1000000);
        add_vertex(CB'(1000000), CB'(-1000000), 1'b0);
        add_vertex(CB'(-1000000), CB'(-1000000), 1'b0);
        add_vertex(CB'(1000000), CB'(1000000), 1'b1);
        add_vertex(CB'(-1000000), CB'(1000000), 1'b1);
        random_polygons(40, 4);
        drain();
        // long stretch without idling, then a long receiver hold-off
        quiet = 1;
        reg_write(REG_CX, 32'd7);
        reg_write(REG_CY, 32'(-3));
        random_polygons(60, 2);
        wait (pending_q.size() < 200);
        quiet = 0;
        holdoff = 3000;
        drain();
        for (int ph = 0; ph < 4; ph++)
        begin
            reg_write(REG_CX, (ph == 0) ? 32'd1000000 : 32'($urandom_range(2000000)) - 1000000);
            reg_write(REG_CY, (ph == 0) ? 32'(-1000000) : 32'($urandom_range(40)) - 20);
            random_polygons(60, 2 + ph % 3);
            drain();
        end
        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end
endmodule
`default_nettype wire
